### rtl/xxhash32_stream_hasher_defines.svh
// Assertion macros for the xxHash32 stream hasher.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef XXHASH32_STREAM_HASHER_DEFINES_SVH
`define XXHASH32_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define XXH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define XXH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/xxh32_pkg.sv
// Shared types, constants and helpers for the xxHash32 stream hasher.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package xxh32_pkg;

  localparam logic [31:0] PRIME1 = 32'h9E3779B1;
  localparam logic [31:0] PRIME2 = 32'h85EBCA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
  localparam logic [31:0] PRIME5 = 32'h165667B1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LANE_MUL,
    ST_LANE_UPD,
    ST_MERGE,
    ST_LENGTH,
    ST_TW_MUL,
    ST_TW_UPD,
    ST_TB_MUL,
    ST_TB_UPD,
    ST_AV1,
    ST_AV2,
    ST_OUT
  } ctrl_state_e;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LANE_MUL,  // mul = word[idx] * P2
    OP_LANE_UPD,  // lane[idx] = rotl(lane[idx] + mul, 13) * P1
    OP_MERGE,     // h = lane merge, or seed + P5
    OP_LENGTH,    // h += byte total
    OP_TW_MUL,    // mul = word[idx] * P3
    OP_TW_UPD,    // h = rotl(h + mul, 17) * P4
    OP_TB_MUL,    // mul = byte[idx] * P5
    OP_TB_UPD,    // h = rotl(h + mul, 11) * P1
    OP_AV1,       // h = (h ^ h >> 15) * P2, message state cleared
    OP_AV2,       // h = (h ^ h >> 13) * P3
    OP_OUT        // hash = h ^ h >> 16
  } dp_op_e;

  typedef struct packed {
    logic       capture;  // input transaction taken this cycle
    dp_op_e     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       in_full_stripe;  // incoming item completes a stripe
    logic       in_last;         // incoming item ends the message
    logic       last_q;          // captured item ended the message
    logic [1:0] tail_words;      // gathered words left for the tail
    logic [1:0] tail_bytes;      // bytes in a short last word
  } dp_status_t;

  // Rotate left by a constant amount (1..31)
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

`default_nettype wire

### rtl/xxhash32_stream_hasher.sv
// xxHash32 stream hasher, top level: joins xxh32_ctrl and xxh32_datapath (xxh32_pkg).
// A message arrives as little-endian 32-bit words, one per input transaction, with a
// byte count and a last flag; one hash comes out per message. An item that does not
// complete a 16-byte stripe is simply taken; one that completes a stripe also runs the
// four lane updates, two steps each, through the one shared 32x32 multiplier, and
// input is not ready meanwhile. After the last item, finalization runs the merge, the
// length add, two steps per tail word and per tail byte and two avalanche steps on the
// shared multiplier, then the output step. The hash sits in an output register, so the
// next message is accepted while it waits. The seed is sampled when the first stripe
// completes, or at finalization for messages shorter than 16 bytes.
`timescale 1ns / 1ps
`default_nettype none

`include "xxhash32_stream_hasher_defines.svh"

module xxhash32_stream_hasher import xxh32_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        seed_we_i,
  input  wire logic [31:0] seed_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      hash_value_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  xxh32_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xxh32_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_i       (seed_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_item_i  (last_item_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .hash_value_o (hash_value_o)
  );

  // A plain mid-stripe word leaves the block ready again on the next cycle
  `XXH_ASSERT_NEXT(a_short_item_ready,
    in_valid_i && in_ready_o && !last_item_i && !status.in_full_stripe,
    in_ready_o, "mid-stripe word did not return to ready")

  // A new hash is never loaded over one that has not been taken
  `XXH_ASSERT_NOW(a_no_overwrite, cmd.op == OP_OUT,
    !out_valid_o || out_ready_i, "pending hash overwritten")

  // A short last item goes straight to the merge step
  `XXH_ASSERT_NEXT(a_last_to_merge,
    in_valid_i && in_ready_o && last_item_i && !status.in_full_stripe,
    cmd.op == OP_MERGE, "last item did not start finalization")

endmodule

`default_nettype wire

### rtl/xxh32_datapath.sv
// Datapath of the xxHash32 stream hasher: message state, lanes, shared multiplier.
// Depends on xxh32_pkg; driven by xxh32_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module xxh32_datapath import xxh32_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        seed_we_i,
  input  wire logic [31:0] seed_i,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_item_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_status_t       status_o,
  output logic [31:0]      hash_value_o
);

  logic [31:0] seed_q;
  logic [31:0] lane_q [4];
  logic [31:0] word_mem_q [4];
  logic [1:0]  wis_q;
  logic [31:0] total_q;
  logic        sdone_q;
  logic        last_q;
  logic [31:0] word_q;
  logic [1:0]  tcnt_q;
  logic [31:0] mul_q;
  logic [31:0] h_q;
  logic [31:0] hash_q;

  logic        full_word;
  logic [31:0] mul_a, mul_b, prod;
  logic [7:0]  tail_byte;
  logic [31:0] merge_sum;

  // Count of four or more, or any count on a non-last item, means a full word
  assign full_word = !last_item_i || byte_count_i[2];

  assign status_o.in_full_stripe = full_word && (wis_q == 2'd3);
  assign status_o.in_last        = last_item_i;
  assign status_o.last_q         = last_q;
  assign status_o.tail_words     = wis_q;
  assign status_o.tail_bytes     = tcnt_q;

  assign tail_byte = 8'(word_q >> {cmd_i.idx, 3'b000});

  assign merge_sum = rotl32(lane_q[0], 1) + rotl32(lane_q[1], 7) +
                     rotl32(lane_q[2], 12) + rotl32(lane_q[3], 18);

  // Operand select for the one shared 32x32 multiplier (low half kept)
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_LANE_MUL: begin
        mul_a = word_mem_q[cmd_i.idx];
        mul_b = PRIME2;
      end
      OP_LANE_UPD: begin
        mul_a = rotl32(lane_q[cmd_i.idx] + mul_q, 13);
        mul_b = PRIME1;
      end
      OP_TW_MUL: begin
        mul_a = word_mem_q[cmd_i.idx];
        mul_b = PRIME3;
      end
      OP_TW_UPD: begin
        mul_a = rotl32(h_q + mul_q, 17);
        mul_b = PRIME4;
      end
      OP_TB_MUL: begin
        mul_a = {24'h000000, tail_byte};
        mul_b = PRIME5;
      end
      OP_TB_UPD: begin
        mul_a = rotl32(h_q + mul_q, 11);
        mul_b = PRIME1;
      end
      OP_AV1: begin
        mul_a = h_q ^ (h_q >> 15);
        mul_b = PRIME2;
      end
      OP_AV2: begin
        mul_a = h_q ^ (h_q >> 13);
        mul_b = PRIME3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_i;
    end
  end

  // Message control state: word count, length, stripe flag, last flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wis_q   <= '0;
      total_q <= '0;
      sdone_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (cmd_i.capture) begin
      last_q  <= last_item_i;
      total_q <= total_q + (full_word ? 32'd4 : {29'd0, byte_count_i});
      if (full_word) begin
        wis_q <= wis_q + 2'd1;
        if (wis_q == 2'd3) begin
          sdone_q <= 1'b1;
        end
      end
    end else if (cmd_i.op == OP_AV1) begin
      wis_q   <= '0;
      total_q <= '0;
      sdone_q <= 1'b0;
    end
  end

  // Stripe words, captured word and short tail count
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q <= data_word_i;
      tcnt_q <= full_word ? 2'd0 : byte_count_i[1:0];
      if (full_word) begin
        word_mem_q[wis_q] <= data_word_i;
      end
    end
  end

  // Lane accumulators: seeded when the first stripe completes
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && full_word && (wis_q == 2'd3) && !sdone_q) begin
      lane_q[0] <= seed_q + PRIME1 + PRIME2;
      lane_q[1] <= seed_q + PRIME2;
      lane_q[2] <= seed_q;
      lane_q[3] <= seed_q - PRIME1;
    end else if (cmd_i.op == OP_LANE_UPD) begin
      lane_q[cmd_i.idx] <= prod;
    end
  end

  // Product register and hash accumulator
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LANE_MUL, OP_TW_MUL, OP_TB_MUL: mul_q <= prod;
      OP_MERGE:  h_q <= sdone_q ? merge_sum : seed_q + PRIME5;
      OP_LENGTH: h_q <= h_q + total_q;
      OP_TW_UPD, OP_TB_UPD, OP_AV1, OP_AV2: h_q <= prod;
      OP_OUT:    hash_q <= h_q ^ (h_q >> 16);
      default: ;
    endcase
  end

  assign hash_value_o = hash_q;

endmodule

`default_nettype wire

### rtl/xxh32_ctrl.sv
// Controller of the xxHash32 stream hasher: sequences stripe, tail and avalanche steps.
// Depends on xxh32_pkg; commands xxh32_datapath and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module xxh32_ctrl import xxh32_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    in_ready_o  = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.op    = OP_IDLE;
    cmd_o.idx   = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        idx_d         = '0;
        if (in_valid_i) begin
          if (status_i.in_full_stripe) begin
            state_d = ST_LANE_MUL;
          end else if (status_i.in_last) begin
            state_d = ST_MERGE;
          end
        end
      end
      ST_LANE_MUL: begin
        cmd_o.op = OP_LANE_MUL;
        state_d  = ST_LANE_UPD;
      end
      ST_LANE_UPD: begin
        cmd_o.op = OP_LANE_UPD;
        if (idx_q == 2'd3) begin
          idx_d   = '0;
          state_d = status_i.last_q ? ST_MERGE : ST_IDLE;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_LANE_MUL;
        end
      end
      ST_MERGE: begin
        cmd_o.op = OP_MERGE;
        state_d  = ST_LENGTH;
      end
      ST_LENGTH: begin
        cmd_o.op = OP_LENGTH;
        idx_d    = '0;
        if (status_i.tail_words != 2'd0) begin
          state_d = ST_TW_MUL;
        end else if (status_i.tail_bytes != 2'd0) begin
          state_d = ST_TB_MUL;
        end else begin
          state_d = ST_AV1;
        end
      end
      ST_TW_MUL: begin
        cmd_o.op = OP_TW_MUL;
        state_d  = ST_TW_UPD;
      end
      ST_TW_UPD: begin
        cmd_o.op = OP_TW_UPD;
        if (idx_q == 2'(status_i.tail_words - 2'd1)) begin
          idx_d   = '0;
          state_d = (status_i.tail_bytes != 2'd0) ? ST_TB_MUL : ST_AV1;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_TW_MUL;
        end
      end
      ST_TB_MUL: begin
        cmd_o.op = OP_TB_MUL;
        state_d  = ST_TB_UPD;
      end
      ST_TB_UPD: begin
        cmd_o.op = OP_TB_UPD;
        if (idx_q == 2'(status_i.tail_bytes - 2'd1)) begin
          idx_d   = '0;
          state_d = ST_AV1;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_TB_MUL;
        end
      end
      ST_AV1: begin
        cmd_o.op = OP_AV1;
        state_d  = ST_AV2;
      end
      ST_AV2: begin
        cmd_o.op = OP_AV2;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### tb/xxhash32_stream_hasher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for xxhash32_stream_hasher: a hash predictor class scores every
// output transaction while plain tasks stream messages in. Depends on xxh32_pkg and the RTL.

module testbench import xxh32_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS  = 850;
  localparam int unsigned SEED_PHASES   = 6;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_e;

  // Predicts the hash of each message from the accepted words and holds the expectations
  class hash_tracker;
    bit [31:0]   seed;
    bit [31:0]   lane [4];
    bit [31:0]   stripe [4];
    int unsigned n_words;
    bit [31:0]   n_bytes;
    bit          striped;
    bit [31:0]   expected_hashes [$];
    int unsigned errors;
    int unsigned n_checked;

    function new();
      seed      = '0;
      errors    = 0;
      n_checked = 0;
      start_message();
    endfunction

    function void start_message();
      for (int k = 0; k < 4; k++) begin
        lane[k]   = '0;
        stripe[k] = '0;
      end
      n_words = 0;
      n_bytes = '0;
      striped = 1'b0;
    endfunction

    function bit [31:0] rotate_left(bit [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    // Gather one full word; a complete stripe updates the four lanes
    function void absorb_word(bit [31:0] w);
      stripe[n_words] = w;
      n_words++;
      if (n_words < 4) return;
      if (!striped) begin
        lane[0] = seed + PRIME1 + PRIME2;
        lane[1] = seed + PRIME2;
        lane[2] = seed;
        lane[3] = seed - PRIME1;
        striped = 1'b1;
      end
      for (int k = 0; k < 4; k++)
        lane[k] = rotate_left(lane[k] + stripe[k] * PRIME2, 13) * PRIME1;
      n_words = 0;
    endfunction

    // Accepted input transaction; a last item queues the expected hash
    function void note_item(bit [31:0] w, bit [2:0] c, bit l);
      bit [2:0]  n;
      bit [31:0] h;
      n = c;
      if (!l || n > 3'd4) n = 3'd4;
      if (n == 3'd4) absorb_word(w);
      n_bytes += n;
      if (!l) return;
      if (striped)
        h = rotate_left(lane[0], 1) + rotate_left(lane[1], 7) +
            rotate_left(lane[2], 12) + rotate_left(lane[3], 18);
      else
        h = seed + PRIME5;
      h += n_bytes;
      for (int k = 0; k < n_words; k++) begin
        h += stripe[k] * PRIME3;
        h = rotate_left(h, 17) * PRIME4;
      end
      if (n < 3'd4) begin
        for (int k = 0; k < n; k++) begin
          h += w[8*k +: 8] * PRIME5;
          h = rotate_left(h, 11) * PRIME1;
        end
      end
      h ^= h >> 15;
      h *= PRIME2;
      h ^= h >> 13;
      h *= PRIME3;
      h ^= h >> 16;
      expected_hashes.insert(expected_hashes.size(), h);
      start_message();
    endfunction

    // Accepted output transaction against the oldest expected hash
    function void check_hash(logic [31:0] got);
      bit [31:0] want;
      if (expected_hashes.size() == 0) begin
        $error("hash_value: no hash expected, actual %08h", got);
        errors++;
        return;
      end
      want = expected_hashes.pop_front();
      n_checked++;
      if (got !== want) begin
        $error("hash_value: expected %08h, actual %08h", want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        seed_we    = 1'b0;
  logic [31:0] seed_val   = '0;
  logic        in_valid   = 1'b0;
  logic [31:0] data_word  = '0;
  logic [2:0]  byte_count = '0;
  logic        last_item  = 1'b0;
  logic        out_ready  = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [31:0] hash_value;

  hash_tracker board;
  int unsigned items_sent    = 0;
  int unsigned seeds_written = 0;
  int unsigned burst_left    = 0;
  int unsigned cycle_count   = 0;
  rx_mode_e    rx_mode       = RX_OPEN;
  int unsigned rx_left       = 0;

  xxhash32_stream_hasher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .seed_we_i   (seed_we),
    .seed_i      (seed_val),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .data_word_i (data_word),
    .byte_count_i(byte_count),
    .last_item_i (last_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hash_value_o(hash_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("xxhash32_stream_hasher: mismatch");
      $finish;
    end
  end

  // Output side: score hashes, stall on a pattern that switches mode now and then
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_hash(hash_value);
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
      default:   out_ready <= ((rx_left % 8) < 3);
    endcase
  end

  // One input transaction; valid stays high on return
  task automatic send_item(input logic [31:0] w, input logic [2:0] c, input logic l);
    in_valid   <= 1'b1;
    data_word  <= w;
    byte_count <= c;
    last_item  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(w, c, l);
    items_sent++;
  endtask

  task automatic hold_off(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Bursts of random length with random gaps in between
  task automatic paced_item(input logic [31:0] w, input logic [2:0] c, input logic l);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
      hold_off($urandom_range(1, 9));
    end
    burst_left--;
    send_item(w, c, l);
  endtask

  // Stop sending until every hash is out and the block has gone quiet
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    seed_we  <= 1'b1;
    seed_val <= v;
    @(posedge clk);
    seed_we <= 1'b0;
    board.seed = v;
    seeds_written++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Count on a non-last word is ignored by the block, so randomize it now and then
  function automatic logic [2:0] filler_count();
    if ($urandom_range(0, 3) == 0) return 3'($urandom_range(0, 7));
    return 3'd4;
  endfunction

  // Mostly short messages, some near stripe boundaries, a few long ones
  function automatic int unsigned pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 20);
      6, 7:             return $urandom_range(21, 70);
      8: begin
        case ($urandom_range(0, 8))
          0: return 15;
          1: return 16;
          2: return 17;
          3: return 31;
          4: return 32;
          5: return 33;
          6: return 47;
          7: return 48;
          default: return 64;
        endcase
      end
      default: return $urandom_range(71, 160);
    endcase
  endfunction

  task automatic send_message(input int unsigned len);
    int unsigned full;
    int unsigned rem;
    logic [2:0]  c;
    full = len / 4;
    rem  = len % 4;
    if (rem == 0 && full > 0 && $urandom_range(0, 1) == 1) begin
      // last word carries four bytes; sometimes with an oversize count
      for (int k = 0; k < full - 1; k++) paced_item(rand_word(), filler_count(), 1'b0);
      c = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
      paced_item(rand_word(), c, 1'b1);
    end else begin
      for (int k = 0; k < full; k++) paced_item(rand_word(), filler_count(), 1'b0);
      paced_item(rand_word(), 3'(rem), 1'b1);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_goal;
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, short tails, oversize count
    write_seed(32'h0000_0000);
    send_item(32'h0000_0000, 3'd0, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_item(32'h0000_0000, 3'd3, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd7, 1'b1);
    // one stripe, counts on non-last words ignored, empty last item
    repeat (4) send_item(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_item(32'h0000_0000, 3'd0, 1'b1);
    // 31 bytes: one stripe, three tail words, three tail bytes
    for (int k = 0; k < 7; k++) send_item(k[0] ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, 1'b0);
    send_item(32'hA5C3_0F96, 3'd3, 1'b1);
    // seed changed mid-message before the first stripe completes: picked up
    wait_quiet();
    write_seed(32'hFFFF_FFFF);
    send_item(32'h0123_4567, 3'd4, 1'b0);
    send_item(32'h89AB_CDEF, 3'd4, 1'b0);
    wait_quiet();
    write_seed(32'h1234_5678);
    send_item(32'hDEAD_BEEF, 3'd5, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd4, 1'b0);
    // seed changed after the lanes were loaded: no effect on this message
    wait_quiet();
    write_seed(32'h0000_0000);
    send_item(32'h0000_BEEF, 3'd2, 1'b1);
    // short message: seed taken at finalization
    send_item(32'h7F7F_7F7F, 3'd4, 1'b0);
    wait_quiet();
    write_seed(32'h9E37_79B1);
    send_item(32'h8080_8080, 3'd3, 1'b1);

    // Random messages under several seeds, draining fully between settings
    for (phase = 0; phase < SEED_PHASES; phase++) begin
      wait_quiet();
      case (phase)
        0:       write_seed(32'hFFFF_FFFF);
        1:       write_seed(32'h0000_0000);
        default: write_seed($urandom());
      endcase
      phase_goal = items_sent + RANDOM_ITEMS / SEED_PHASES;
      while (items_sent < phase_goal) begin
        send_message(pick_length());
        if ($urandom_range(0, 19) == 0) wait_quiet();
      end
    end

    wait_quiet();
    $display("Streamed %0d words and checked %0d hashes under %0d seed writes.",
             items_sent, board.n_checked, seeds_written);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("xxhash32_stream_hasher: match");
    end else begin
      $display("xxhash32_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule
